// ===== hdl/assert_macros.svh =====
// assertion macros for the rtl top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pidc_pkg.sv =====
// types, constants and helpers for the clamped pid controller
package pidc_pkg;

  localparam int unsigned AccW   = 48;
  localparam int unsigned DataW  = 32;
  localparam int unsigned DtW    = 17;
  localparam int unsigned ProdW  = 66;
  localparam int unsigned FracW  = 16;

  // register indexes on the config port
  localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [2:0] REG_OUT_UPPER  = 3'd3;
  localparam logic [2:0] REG_OUT_LOWER  = 3'd4;
  localparam logic [2:0] REG_TIME_STEP  = 3'd5;

  localparam logic signed [DataW-1:0] UPPER_RST = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] LOWER_RST = 32'sh8000_0000;
  localparam logic [DtW-1:0]          DT_RST    = 17'd1049;

  localparam logic signed [AccW-1:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [AccW-1:0] ACC_MIN = 48'sh8000_0000_0000;

  // sequencer, one multiply issued per working state but the last
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MKD  = 9'b000000010,
    S_DSUB = 9'b000000100,
    S_PADD = 9'b000001000,
    S_IHI  = 9'b000010000,
    S_ILO  = 9'b000100000,
    S_DHI  = 9'b001000000,
    S_DLO  = 9'b010000000,
    S_XDT  = 9'b100000000
  } state_t;

  // saturate a wide signed value to the 48-bit accumulator range
  function automatic logic signed [AccW-1:0] sat48(input logic signed [ProdW-1:0] v);
    logic signed [ProdW-1:0] hi;
    logic signed [ProdW-1:0] lo;
    hi = ProdW'(ACC_MAX);
    lo = ProdW'(ACC_MIN);
    if (v > hi) begin
      sat48 = ACC_MAX;
    end else if (v < lo) begin
      sat48 = ACC_MIN;
    end else begin
      sat48 = v[AccW-1:0];
    end
  endfunction

endpackage

// ===== hdl/pid_controller_clamped_top.sv =====
// clamped q16.16 pid controller, one shared 33x33 multiplier under a sequencer
// each result is registered at the output step; one multiply per working state but the last
// the next input can already be taken in the last working state
// a result still stalled in the output register holds the sequencer at its output step
// reset (rst_n low, synchronous) clears both accumulators, the sequencer and out_valid,
// and loads the gain, clamp and time step registers with their defaults
`include "assert_macros.svh"

module pid_controller_clamped_top (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  in_error_in,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_drive_out,
  output logic                out_clamped,
  // config write port
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);

  // config registers
  logic signed [31:0] kp_r;
  logic signed [31:0] ki_r;
  logic signed [31:0] kd_r;
  logic signed [31:0] upper_r;
  logic signed [31:0] lower_r;
  logic [16:0]        dt_r;

  // sequencer and datapath registers
  pidc_pkg::state_t   state_r, state_nxt;
  logic signed [31:0] x_r, x_nxt;
  logic signed [65:0] mul_r, mul_nxt;
  logic signed [47:0] d_r, d_nxt;
  logic signed [65:0] y_r, y_nxt;
  logic signed [51:0] u_r, u_nxt;
  logic signed [47:0] dacc_r, dacc_nxt;
  logic signed [47:0] iacc_r, iacc_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] drive_r, drive_nxt;
  logic               clamped_r, clamped_nxt;

  logic               in_xfer;
  logic               out_xfer;
  logic               out_free;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [65:0] mul_q16;     // product floored by 2^16
  logic signed [65:0] lo_ext, up_ext;
  logic signed [65:0] clamp_lo;
  logic               hit_lo, hit_up;

  // new item only when idle or finishing the last step
  assign in_stall = !((state_r == pidc_pkg::S_IDLE) || (state_r == pidc_pkg::S_XDT));
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  // result register can take a new value this edge
  assign out_free = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_drive_out = drive_r;
  assign out_clamped   = clamped_r;

  // operand select for the shared multiplier, by issuing state
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      pidc_pkg::S_MKD: begin
        mul_a = 33'(kd_r);
        mul_b = 33'(x_r);
      end
      pidc_pkg::S_DSUB: begin
        mul_a = 33'(kp_r);
        mul_b = 33'(x_r);
      end
      // ki times integral, high signed half then low unsigned half
      pidc_pkg::S_PADD: begin
        mul_a = 33'(ki_r);
        mul_b = 33'($signed(iacc_r[47:16]));
      end
      pidc_pkg::S_IHI: begin
        mul_a = 33'(ki_r);
        mul_b = $signed({17'd0, iacc_r[15:0]});
      end
      // dt times derivative term, same split
      pidc_pkg::S_ILO: begin
        mul_a = $signed({16'd0, dt_r});
        mul_b = 33'($signed(d_r[47:16]));
      end
      pidc_pkg::S_DHI: begin
        mul_a = $signed({16'd0, dt_r});
        mul_b = $signed({17'd0, d_r[15:0]});
      end
      pidc_pkg::S_DLO: begin
        mul_a = $signed({16'd0, dt_r});
        mul_b = 33'(x_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign mul_q16 = 66'($signed(mul_r[65:16]));

  // output clamp: lower limit first, then upper
  assign lo_ext   = 66'(lower_r);
  assign up_ext   = 66'(upper_r);
  assign hit_lo   = y_r < lo_ext;
  assign clamp_lo = hit_lo ? lo_ext : y_r;
  assign hit_up   = clamp_lo > up_ext;

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    mul_nxt       = mul_r;
    d_nxt         = d_r;
    y_nxt         = y_r;
    u_nxt         = u_r;
    dacc_nxt      = dacc_r;
    iacc_nxt      = iacc_r;
    out_valid_nxt = out_xfer ? 1'b0 : out_valid_r;
    drive_nxt     = drive_r;
    clamped_nxt   = clamped_r;

    if (in_xfer) begin
      x_nxt = in_error_in;
    end

    case (state_r)
      pidc_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_nxt = pidc_pkg::S_MKD;
        end
      end
      pidc_pkg::S_MKD: begin
        mul_nxt   = mul_p;
        state_nxt = pidc_pkg::S_DSUB;
      end
      // d = sat(kd*x - last)
      pidc_pkg::S_DSUB: begin
        d_nxt     = pidc_pkg::sat48(mul_q16 - 66'(dacc_r));
        mul_nxt   = mul_p;
        state_nxt = pidc_pkg::S_PADD;
      end
      pidc_pkg::S_PADD: begin
        y_nxt     = mul_q16 + 66'(d_r);
        mul_nxt   = mul_p;
        state_nxt = pidc_pkg::S_IHI;
      end
      // high half product is already in q16.16
      pidc_pkg::S_IHI: begin
        y_nxt     = y_r + mul_r;
        mul_nxt   = mul_p;
        state_nxt = pidc_pkg::S_ILO;
      end
      pidc_pkg::S_ILO: begin
        y_nxt     = y_r + mul_q16;
        mul_nxt   = mul_p;
        state_nxt = pidc_pkg::S_DHI;
      end
      // result goes out here; wait while the previous one is still held
      pidc_pkg::S_DHI: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          drive_nxt     = hit_up ? upper_r : clamp_lo[31:0];
          clamped_nxt   = hit_lo || hit_up;
          u_nxt         = 52'(dacc_r) + $signed(mul_r[51:0]);
          mul_nxt       = mul_p;
          state_nxt     = pidc_pkg::S_DLO;
        end
      end
      pidc_pkg::S_DLO: begin
        dacc_nxt  = pidc_pkg::sat48(66'(u_r) + mul_q16);
        mul_nxt   = mul_p;
        state_nxt = pidc_pkg::S_XDT;
      end
      pidc_pkg::S_XDT: begin
        iacc_nxt  = pidc_pkg::sat48(66'(iacc_r) + mul_q16);
        state_nxt = in_xfer ? pidc_pkg::S_MKD : pidc_pkg::S_IDLE;
      end
      default: begin
        state_nxt = pidc_pkg::S_IDLE;
      end
    endcase
  end

  // control state and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pidc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      dacc_r      <= '0;
      iacc_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      dacc_r      <= dacc_nxt;
      iacc_r      <= iacc_nxt;
    end
  end

  // datapath payload, no reset needed
  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    mul_r     <= mul_nxt;
    d_r       <= d_nxt;
    y_r       <= y_nxt;
    u_r       <= u_nxt;
    drive_r   <= drive_nxt;
    clamped_r <= clamped_nxt;
  end

  // config registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r    <= '0;
      ki_r    <= '0;
      kd_r    <= '0;
      upper_r <= pidc_pkg::UPPER_RST;
      lower_r <= pidc_pkg::LOWER_RST;
      dt_r    <= pidc_pkg::DT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pidc_pkg::REG_PROP_GAIN:  kp_r    <= $signed(cfg_wdata);
        pidc_pkg::REG_INTEG_GAIN: ki_r    <= $signed(cfg_wdata);
        pidc_pkg::REG_DERIV_GAIN: kd_r    <= $signed(cfg_wdata);
        pidc_pkg::REG_OUT_UPPER:  upper_r <= $signed(cfg_wdata);
        pidc_pkg::REG_OUT_LOWER:  lower_r <= $signed(cfg_wdata);
        pidc_pkg::REG_TIME_STEP:  dt_r    <= cfg_wdata[16:0];
        default: begin
        end
      endcase
    end
  end

  // input transfers only at the ends of the sequence
  `CHK_SAME(a_in_when_free, in_valid && !in_stall,
    (state_r == pidc_pkg::S_IDLE) || (state_r == pidc_pkg::S_XDT), "input transfer while busy")
  // a new result appears only from the output step
  `CHK_NEXT(a_out_from_dhi, !out_valid_r && (state_r != pidc_pkg::S_DHI), !out_valid_r,
    "result without output step")
  // clamp flag implies the output sits on a limit
  `CHK_SAME(a_clamp_limit, out_valid_r && clamped_r,
    (drive_r == upper_r) || (drive_r == lower_r), "clamp flag off limit")
  // derivative accumulator changes only in its update step
  `CHK_NEXT(a_dacc_hold, state_r != pidc_pkg::S_DLO, $stable(dacc_r),
    "derivative accumulator moved")

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for the clamped q16.16 pid controller
`timescale 1ns / 100ps

module tb_top;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               clamped;
  } drive_result_t;

  // indexes that map to no register, writes there must be dropped
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  localparam int unsigned SETTLE_CYCLES = 10;  // covers the update steps after the last result
  localparam int unsigned STUCK_LIMIT   = 2000;
  localparam int unsigned RAND_PHASES   = 9;
  localparam int unsigned PHASE_ITEMS   = 50;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // block ports, the inputs driven to known values from time zero
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_error_in = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic signed [31:0] out_drive_out;
  logic               out_clamped;
  logic               cfg_we      = 1'b0;
  logic [2:0]         cfg_index   = '0;
  logic [31:0]        cfg_wdata   = '0;

  pid_controller_clamped_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_error_in  (in_error_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_drive_out(out_drive_out),
    .out_clamped  (out_clamped),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  // controller copy: register shadows and the two accumulators
  logic signed [31:0] kp_reg;
  logic signed [31:0] ki_reg;
  logic signed [31:0] kd_reg;
  logic signed [31:0] upper_reg;
  logic signed [31:0] lower_reg;
  logic [16:0]        dt_reg;
  logic signed [47:0] deriv_acc;
  logic signed [47:0] integ_acc;

  // error samples waiting to be sent, and drive results waiting to come back
  logic [31:0]   error_samples_q[$];
  drive_result_t drive_results_q[$];

  int  fail_count   = 0;
  int  stuck_cycles = 0;
  bit  idle_en      = 1'b1;
  bit  in_taken     = 1'b0;
  int  gap_left     = 0;
  int  stall_left   = 0;

  // q16.16 product, exact then floored by the arithmetic shift
  function automatic logic signed [95:0] fx_mul(input logic signed [95:0] a,
                                                input logic signed [95:0] b);
    fx_mul = (a * b) >>> 16;
  endfunction

  function automatic logic signed [47:0] sat_acc(input logic signed [95:0] v);
    logic signed [95:0] top;
    logic signed [95:0] bot;
    top = 96'(pidc_pkg::ACC_MAX);
    bot = 96'(pidc_pkg::ACC_MIN);
    if (v > top) begin
      sat_acc = pidc_pkg::ACC_MAX;
    end else if (v < bot) begin
      sat_acc = pidc_pkg::ACC_MIN;
    end else begin
      sat_acc = v[47:0];
    end
  endfunction

  // one controller step: output from the current state, then both accumulators advance
  task automatic compute_drive(input logic signed [31:0] err, output drive_result_t res);
    logic signed [95:0] x;
    logic signed [95:0] d;
    logic signed [95:0] y;
    logic signed [95:0] dtw;
    logic signed [95:0] lo;
    logic signed [95:0] hi;
    logic               hit;
    x   = 96'(err);
    dtw = {79'd0, dt_reg};
    d   = 96'(sat_acc(fx_mul(96'(kd_reg), x) - deriv_acc));
    y   = fx_mul(96'(kp_reg), x) + fx_mul(96'(ki_reg), 96'(integ_acc)) + d;
    deriv_acc = sat_acc(deriv_acc + fx_mul(dtw, d));
    integ_acc = sat_acc(integ_acc + fx_mul(dtw, x));
    // lower limit first, upper second, so crossed limits end on the upper one
    lo  = 96'(lower_reg);
    hi  = 96'(upper_reg);
    hit = 1'b0;
    if (y < lo) begin
      y   = lo;
      hit = 1'b1;
    end
    if (y > hi) begin
      y   = hi;
      hit = 1'b1;
    end
    res.drive   = y[31:0];
    res.clamped = hit;
  endtask

  // register write on the config port, shadow follows at once since nothing is in flight
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      pidc_pkg::REG_PROP_GAIN:  kp_reg    = val;
      pidc_pkg::REG_INTEG_GAIN: ki_reg    = val;
      pidc_pkg::REG_DERIV_GAIN: kd_reg    = val;
      pidc_pkg::REG_OUT_UPPER:  upper_reg = val;
      pidc_pkg::REG_OUT_LOWER:  lower_reg = val;
      pidc_pkg::REG_TIME_STEP:  dt_reg    = val[16:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // sender holds off here until every sent sample has its result back
  task automatic wait_results();
    while (error_samples_q.size() != 0 || drive_results_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // extremes, unit values and small signed values mixed in with plain random words
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       pick_word = 32'h7FFF_FFFF;
      1:       pick_word = 32'h8000_0000;
      2:       pick_word = 32'h0000_0000;
      3:       pick_word = $urandom_range(0, 32'h3FFFF) - 32'h1FFFF;
      4:       pick_word = 32'hFFFF_FFFF;
      5:       pick_word = 32'h0001_0000;
      default: pick_word = $urandom();
    endcase
  endfunction

  function automatic logic [31:0] gain_word();
    case ($urandom_range(0, 9))
      0:       gain_word = 32'h0000_0000;
      1:       gain_word = 32'h7FFF_FFFF;
      2:       gain_word = 32'h8000_0000;
      3:       gain_word = 32'h0001_0000;
      4:       gain_word = 32'hFFFF_0000;
      5:       gain_word = $urandom();
      // moderate gains keep the loop out of the clamps most of the time
      default: gain_word = $urandom_range(0, 32'h7FFFF) - 32'h3FFFF;
    endcase
  endfunction

  task automatic randomize_config();
    logic [31:0] a;
    logic [31:0] b;
    logic [16:0] dt;
    write_reg(pidc_pkg::REG_PROP_GAIN,  gain_word());
    write_reg(pidc_pkg::REG_INTEG_GAIN, gain_word());
    write_reg(pidc_pkg::REG_DERIV_GAIN, gain_word());
    a = $urandom_range(0, 32'h00FF_FFFF);
    b = $urandom_range(0, 32'h00FF_FFFF);
    case ($urandom_range(0, 5))
      0: begin
        // widest window
        write_reg(pidc_pkg::REG_OUT_UPPER, 32'h7FFF_FFFF);
        write_reg(pidc_pkg::REG_OUT_LOWER, 32'h8000_0000);
      end
      1: begin
        // crossed limits
        write_reg(pidc_pkg::REG_OUT_UPPER, -a);
        write_reg(pidc_pkg::REG_OUT_LOWER, b);
      end
      2: begin
        write_reg(pidc_pkg::REG_OUT_UPPER, $urandom());
        write_reg(pidc_pkg::REG_OUT_LOWER, $urandom());
      end
      default: begin
        write_reg(pidc_pkg::REG_OUT_UPPER, b);
        write_reg(pidc_pkg::REG_OUT_LOWER, -a);
      end
    endcase
    case ($urandom_range(0, 5))
      0:       dt = 17'd0;
      1:       dt = pidc_pkg::DT_RST;
      2:       dt = 17'h10000;
      3:       dt = 17'h1FFFF;
      default: dt = 17'($urandom_range(0, 17'h1FFFF));
    endcase
    // junk in the unused upper bits of the time step write
    write_reg(pidc_pkg::REG_TIME_STEP, ($urandom() & 32'hFFFE_0000) | dt);
    if ($urandom_range(0, 3) == 0) begin
      write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, $urandom());
    end
  endtask

  // input driver: new sample or a gap at the falling edge, payload frozen while stalled
  always @(negedge clk) begin
    if (!(in_valid && !in_taken)) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (error_samples_q.size() != 0) begin
        if (idle_en && $urandom_range(0, 5) == 0) begin
          // gap of random length, gap_left more idle cycles after this one
          gap_left = $urandom_range(0, 8);
          in_valid <= 1'b0;
        end else begin
          in_valid    <= 1'b1;
          in_error_in <= error_samples_q[0];
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure in bursts, stall_left more stalled cycles after the first
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: both transfers sampled at the rising edge
  always @(posedge clk) begin
    drive_result_t want;
    drive_result_t got;
    bit            moved;
    moved = 1'b0;
    if (rst_n) begin
      // result first, its sample was taken at an earlier edge
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (drive_results_q.size() == 0) begin
          $error("result with no sample pending: drive_out %0d clamped %0b",
                 out_drive_out, out_clamped);
          fail_count++;
        end else begin
          want = drive_results_q.pop_front();
          got.drive   = out_drive_out;
          got.clamped = out_clamped;
          if (got.drive !== want.drive) begin
            $error("drive_out mismatch: expected %0d, actual %0d", want.drive, got.drive);
            fail_count++;
          end
          if (got.clamped !== want.clamped) begin
            $error("clamped mismatch: expected %0b, actual %0b", want.clamped, got.clamped);
            fail_count++;
          end
        end
      end
      // sample transfer advances the controller copy
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        compute_drive(in_error_in, want);
        drive_results_q.push_back(want);
        void'(error_samples_q.pop_front());
        in_taken = 1'b1;
      end
      if (cfg_we) begin
        moved = 1'b1;
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
    end
  end

  // watchdog on cycles with no transfer of any kind
  initial begin
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk);
    end
    $display("*** FAILED ***");
    $finish;
  end

  // stimulus sequence
  initial begin
    kp_reg    = '0;
    ki_reg    = '0;
    kd_reg    = '0;
    upper_reg = pidc_pkg::UPPER_RST;
    lower_reg = pidc_pkg::LOWER_RST;
    dt_reg    = pidc_pkg::DT_RST;
    deriv_acc = '0;
    integ_acc = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // register defaults after reset
    error_samples_q.push_back(32'h0000_0000);
    error_samples_q.push_back(32'h7FFF_FFFF);
    error_samples_q.push_back(32'h8000_0000);
    wait_idle();

    // full-scale derivative gain with the largest time step: the derivative
    // accumulator swings and saturates low on the first negative sample
    write_reg(pidc_pkg::REG_PROP_GAIN,  32'h0001_0000);
    write_reg(pidc_pkg::REG_INTEG_GAIN, 32'h0001_0000);
    write_reg(pidc_pkg::REG_DERIV_GAIN, 32'h7FFF_FFFF);
    write_reg(pidc_pkg::REG_TIME_STEP,  32'h0001_FFFF);
    error_samples_q.push_back(32'h7FFF_FFFF);
    error_samples_q.push_back(32'h7FFF_FFFF);
    error_samples_q.push_back(32'h8000_0000);
    error_samples_q.push_back(32'h8000_0000);
    error_samples_q.push_back(32'h0000_0000);
    error_samples_q.push_back(32'hFFFF_FFFF);
    wait_idle();

    // pure unit proportional path; a unit time step with no derivative gain
    // drains the derivative accumulator to zero within two samples
    write_reg(pidc_pkg::REG_INTEG_GAIN, 32'h0000_0000);
    write_reg(pidc_pkg::REG_DERIV_GAIN, 32'h0000_0000);
    write_reg(pidc_pkg::REG_TIME_STEP,  32'h0001_0000);
    repeat (3) error_samples_q.push_back(32'h0000_0000);
    wait_idle();

    // output landing on a limit is not flagged, one lsb beyond is
    write_reg(pidc_pkg::REG_OUT_UPPER, 32'h0005_0000);
    write_reg(pidc_pkg::REG_OUT_LOWER, 32'hFFFB_0000);
    error_samples_q.push_back(32'h0005_0000);
    error_samples_q.push_back(32'h0005_0001);
    error_samples_q.push_back(32'hFFFB_0000);
    error_samples_q.push_back(32'hFFFA_FFFF);
    wait_idle();

    // crossed limits, the upper one wins
    write_reg(pidc_pkg::REG_OUT_UPPER, 32'hFFFF_FF00);
    write_reg(pidc_pkg::REG_OUT_LOWER, 32'h0000_0100);
    error_samples_q.push_back(32'h0000_0000);
    error_samples_q.push_back(32'h0000_1000);
    error_samples_q.push_back(32'hFFFF_FF00);
    error_samples_q.push_back(32'h0000_0100);
    wait_idle();

    // zero time step freezes both accumulators; spare indexes change nothing
    write_reg(pidc_pkg::REG_TIME_STEP, 32'hFFFE_0000);
    write_reg(REG_SPARE_6, $urandom());
    write_reg(REG_SPARE_7, $urandom());
    write_reg(pidc_pkg::REG_INTEG_GAIN, 32'h8000_0000);
    error_samples_q.push_back($urandom());
    error_samples_q.push_back($urandom());
    wait_idle();

    // random phases, each under its own register setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      // no idling on either side in the last phase, now and then none in others
      idle_en = (ph < RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
      randomize_config();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 2 && i == PHASE_ITEMS / 2) begin
          wait_results();
        end
        error_samples_q.push_back($urandom_range(0, 1) ? pick_word() : $urandom());
      end
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && drive_results_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== pid_controller_clamped_top.f =====
+incdir+hdl
hdl/pidc_pkg.sv
hdl/pid_controller_clamped_top.sv
sim/tb_top.sv
